// ===== rtl/lcmp_pkg.sv =====
// shared constants for the lossless context model and median predictor
// no dependencies; used by every module in rtl/
package lcmp_pkg;

    localparam int DEF_TABLE_SIZE  = 256;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int NUM_TABLES      = 5;

    // fixed field widths of the item ports
    localparam int FIELD_W = 16;
    localparam int SEL_W   = 3;
    localparam int TIDX_W  = 8;
    localparam int CTX_W   = 19;

    // entry whose contents switch between three and five tables
    localparam int MID_ENTRY = 127;

    // command codes
    localparam logic CMD_COMPUTE = 1'b0;
    localparam logic CMD_WRITE   = 1'b1;

    // table select codes that carry the mid-entry flags
    localparam logic [SEL_W-1:0] SEL_TABLE3 = 3'd3;
    localparam logic [SEL_W-1:0] SEL_TABLE4 = 3'd4;

endpackage

// ===== rtl/lossless_context_and_median_predict.sv =====
// lossless context modeller and median predictor, top level
// out_valid follows item acceptance: table read into stage 1, then the registered sum
// throughput: one item per clock while the output is not stalled; table writes produce no result
// rate is set by the single registered read port of each table bank
// reset clears pipeline valids and the mid-entry flags; tables undefined until written
// depends on lcmp_pkg, lcmp_front, lcmp_qbank
module lossless_context_and_median_predict
    import lcmp_pkg::*;
#(
    parameter int TABLE_SIZE  = DEF_TABLE_SIZE,   // power of two, 16..256
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      cmd,
    input  logic signed [FIELD_W-1:0] left,
    input  logic signed [FIELD_W-1:0] top,
    input  logic signed [FIELD_W-1:0] top_left,
    input  logic signed [FIELD_W-1:0] top_right,
    input  logic signed [FIELD_W-1:0] left_left,
    input  logic signed [FIELD_W-1:0] top_top,
    input  logic [SEL_W-1:0]          table_select,
    input  logic [TIDX_W-1:0]         table_index,
    input  logic signed [FIELD_W-1:0] table_value,

    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [FIELD_W-1:0] prediction,
    output logic signed [CTX_W-1:0]   context_res
);

    localparam int IDX_W = $clog2(TABLE_SIZE);

    // ------------------------------------------------------------------
    // handshake and pipeline advance
    // stage 1 holds the item while table data comes back from the banks,
    // the output register holds the finished result
    // ------------------------------------------------------------------
    logic s1_valid_reg, s1_valid_next;
    logic out_valid_reg, out_valid_next;
    logic advance;
    logic accept;
    logic compute_acc;
    logic write_acc;

    assign advance     = !out_valid_reg || out_ready;
    assign in_ready    = !s1_valid_reg || advance;
    assign accept      = in_valid && in_ready;
    assign compute_acc = accept && (cmd == CMD_COMPUTE);
    assign write_acc   = accept && (cmd == CMD_WRITE);

    // ------------------------------------------------------------------
    // table writes: out-of-range select or index is dropped
    // ------------------------------------------------------------------
    logic write_ok;
    logic mid_hit;

    assign write_ok = write_acc
                   && (table_select < SEL_W'(NUM_TABLES))
                   && ({1'b0, table_index} < (TIDX_W+1)'(TABLE_SIZE));
    assign mid_hit  = (table_index == TIDX_W'(MID_ENTRY));

    // flags track whether entry 127 of tables 3 and 4 is nonzero
    logic t3_mid_reg, t3_mid_next;
    logic t4_mid_reg, t4_mid_next;

    always_comb
    begin
        t3_mid_next = t3_mid_reg;
        t4_mid_next = t4_mid_reg;
        if (write_ok && mid_hit && (table_select == SEL_TABLE3))
        begin
            t3_mid_next = (table_value != '0);
        end
        if (write_ok && mid_hit && (table_select == SEL_TABLE4))
        begin
            t4_mid_next = (table_value != '0);
        end
    end

    // ------------------------------------------------------------------
    // front end: prediction and lookup indexes straight from the ports
    // ------------------------------------------------------------------
    logic signed [FIELD_W-1:0]             pred_comb;
    logic [NUM_TABLES-1:0][IDX_W-1:0]      rd_idx;
    logic [NUM_TABLES-1:0][FIELD_W-1:0]    q;

    lcmp_front #(
        .TABLE_SIZE  (TABLE_SIZE),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .left      (left),
        .top       (top),
        .top_left  (top_left),
        .top_right (top_right),
        .left_left (left_left),
        .top_top   (top_top),
        .pred      (pred_comb),
        .idx       (rd_idx)
    );

    // ------------------------------------------------------------------
    // one bank per table; each compute item reads all five in parallel.
    // a write and a read never share a cycle, and a read issued after a
    // write sees it, so no forwarding is needed
    // ------------------------------------------------------------------
    for (genvar b = 0; b < NUM_TABLES; b++)
    begin : g_bank
        lcmp_qbank #(
            .TABLE_SIZE (TABLE_SIZE)
        ) u_bank (
            .clk     (clk),
            .wr_en   (write_ok && (table_select == SEL_W'(b))),
            .wr_addr (table_index[IDX_W-1:0]),
            .wr_data (table_value),
            .rd_en   (compute_acc),
            .rd_addr (rd_idx[b]),
            .rd_data (q[b])
        );
    end

    // ------------------------------------------------------------------
    // stage 1 payload: prediction and the three/five table choice,
    // sampled with the flags as they stand when the item is taken
    // ------------------------------------------------------------------
    logic signed [FIELD_W-1:0] s1_pred_reg;
    logic                      s1_five_reg;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        if (compute_acc)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (compute_acc)
        begin
            s1_pred_reg <= pred_comb;
            s1_five_reg <= t3_mid_reg || t4_mid_reg;
        end
    end

    // ------------------------------------------------------------------
    // context sum over the table outputs
    // ------------------------------------------------------------------
    logic signed [CTX_W-1:0] ctx_comb;
    logic signed [CTX_W-1:0] e0, e1, e2, e3, e4;

    always_comb
    begin
        e0 = CTX_W'(signed'(q[0]));
        e1 = CTX_W'(signed'(q[1]));
        e2 = CTX_W'(signed'(q[2]));
        e3 = s1_five_reg ? CTX_W'(signed'(q[3])) : '0;
        e4 = s1_five_reg ? CTX_W'(signed'(q[4])) : '0;
        ctx_comb = e0 + e1 + e2 + e3 + e4;
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic signed [FIELD_W-1:0] pred_out_reg;
    logic signed [CTX_W-1:0]   ctx_out_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            pred_out_reg <= s1_pred_reg;
            ctx_out_reg  <= ctx_comb;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            t3_mid_reg    <= 1'b0;
            t4_mid_reg    <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            t3_mid_reg    <= t3_mid_next;
            t4_mid_reg    <= t4_mid_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign prediction  = pred_out_reg;
    assign context_res = ctx_out_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_compute_enters: assert property (@(posedge clk) disable iff (!rst_n)
        compute_acc |=> s1_valid_reg)
        else $error("compute item did not enter stage 1");

    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> (s1_valid_reg && $stable(s1_pred_reg)))
        else $error("stalled stage 1 item lost or changed");

    a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && advance) |=> out_valid_reg)
        else $error("stage 1 item did not reach the output register");

    a_t3_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (write_ok && mid_hit && (table_select == SEL_TABLE3))
            |=> (t3_mid_reg == ($past(table_value) != '0)))
        else $error("table 3 mid-entry flag not updated");

endmodule

// ===== rtl/lcmp_qbank.sv =====
// one quantization table bank: single write port, single registered read port
// depends on lcmp_pkg for the default depth and entry width
module lcmp_qbank
    import lcmp_pkg::*;
#(
    parameter int TABLE_SIZE = DEF_TABLE_SIZE
)
(
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [$clog2(TABLE_SIZE)-1:0] wr_addr,
    input  logic [FIELD_W-1:0]            wr_data,
    input  logic                          rd_en,
    input  logic [$clog2(TABLE_SIZE)-1:0] rd_addr,
    output logic [FIELD_W-1:0]            rd_data
);

    logic [FIELD_W-1:0] mem [TABLE_SIZE];
    logic [FIELD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/lcmp_front.sv =====
// front end: sample sign extension, median prediction, table lookup indexes
// depends on lcmp_pkg for field widths and table count
module lcmp_front
    import lcmp_pkg::*;
#(
    parameter int TABLE_SIZE  = DEF_TABLE_SIZE,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
)
(
    input  logic signed [FIELD_W-1:0]                          left,
    input  logic signed [FIELD_W-1:0]                          top,
    input  logic signed [FIELD_W-1:0]                          top_left,
    input  logic signed [FIELD_W-1:0]                          top_right,
    input  logic signed [FIELD_W-1:0]                          left_left,
    input  logic signed [FIELD_W-1:0]                          top_top,
    output logic signed [FIELD_W-1:0]                          pred,
    output logic [NUM_TABLES-1:0][$clog2(TABLE_SIZE)-1:0]      idx
);

    localparam int IDX_W = $clog2(TABLE_SIZE);
    // samples use at most the field width
    localparam int SW    = (SAMPLE_BITS > FIELD_W) ? FIELD_W : SAMPLE_BITS;
    // working width holds the gradient and all differences
    localparam int EW    = FIELD_W + 2;

    logic signed [EW-1:0] l, t, lt, rt, ll, tt;
    logic signed [EW-1:0] grad, lo, hi, mid, med;
    logic signed [EW-1:0] d0, d1, d2, d3, d4;

    always_comb
    begin
        l  = {{(EW-SW){left[SW-1]}},      left[SW-1:0]};
        t  = {{(EW-SW){top[SW-1]}},       top[SW-1:0]};
        lt = {{(EW-SW){top_left[SW-1]}},  top_left[SW-1:0]};
        rt = {{(EW-SW){top_right[SW-1]}}, top_right[SW-1:0]};
        ll = {{(EW-SW){left_left[SW-1]}}, left_left[SW-1:0]};
        tt = {{(EW-SW){top_top[SW-1]}},   top_top[SW-1:0]};

        grad = l + t - lt;
        lo   = (l < grad) ? l : grad;
        hi   = (l < grad) ? grad : l;
        mid  = (hi < t) ? hi : t;
        med  = (lo > mid) ? lo : mid;

        d0 = l  - lt;
        d1 = lt - t;
        d2 = t  - rt;
        d3 = ll - l;
        d4 = tt - t;
    end

    // median lies between left and top, so it fits the field
    assign pred = med[FIELD_W-1:0];

    // index is the difference modulo the table size
    assign idx[0] = d0[IDX_W-1:0];
    assign idx[1] = d1[IDX_W-1:0];
    assign idx[2] = d2[IDX_W-1:0];
    assign idx[3] = d3[IDX_W-1:0];
    assign idx[4] = d4[IDX_W-1:0];

endmodule

// ===== test/tb.sv =====
// self-checking testbench for lossless_context_and_median_predict
// loads the quantization tables, then checks the median prediction and context sum of every pixel
// depends on lcmp_pkg and the sources under rtl/
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lcmp_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int TB_TABLE_SIZE  = DEF_TABLE_SIZE;
    localparam int IDX_MASK       = TB_TABLE_SIZE - 1;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 64;
    // pipeline is two deep; the extra settle cycles let a trailing table write land
    localparam int SETTLE_CYCLES  = 4;

    // one item as offered on the input channel
    typedef struct {
        logic                      cmd;
        logic signed [FIELD_W-1:0] left;
        logic signed [FIELD_W-1:0] top;
        logic signed [FIELD_W-1:0] top_left;
        logic signed [FIELD_W-1:0] top_right;
        logic signed [FIELD_W-1:0] left_left;
        logic signed [FIELD_W-1:0] top_top;
        logic [SEL_W-1:0]          tsel;
        logic [TIDX_W-1:0]         tidx;
        logic signed [FIELD_W-1:0] tval;
    } pixel_item_t;

    // what one compute item must produce
    typedef struct {
        logic signed [FIELD_W-1:0] pred;
        logic signed [CTX_W-1:0]   ctx;
    } pixel_result_t;

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      in_valid     = 1'b0;
    logic                      in_ready;
    logic                      cmd          = CMD_COMPUTE;
    logic signed [FIELD_W-1:0] left         = '0;
    logic signed [FIELD_W-1:0] top          = '0;
    logic signed [FIELD_W-1:0] top_left     = '0;
    logic signed [FIELD_W-1:0] top_right    = '0;
    logic signed [FIELD_W-1:0] left_left    = '0;
    logic signed [FIELD_W-1:0] top_top      = '0;
    logic [SEL_W-1:0]          table_select = '0;
    logic [TIDX_W-1:0]         table_index  = '0;
    logic signed [FIELD_W-1:0] table_value  = '0;
    logic                      out_valid;
    logic                      out_ready    = 1'b0;
    logic signed [FIELD_W-1:0] prediction;
    logic signed [CTX_W-1:0]   context_res;

    // items waiting to be offered, and results owed by the block, oldest first
    pixel_item_t   pending_items[$];
    pixel_result_t expected_pixels[$];
    pixel_item_t   item_on_bus;
    pixel_result_t want;

    // local copy of the quantization tables and the two mid-entry flags
    logic signed [FIELD_W-1:0] qtab_model [NUM_TABLES*TB_TABLE_SIZE];
    bit mid3_set;
    bit mid4_set;

    // idle mix, set per phase by the stimulus process
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // bookkeeping
    int errors            = 0;
    int results_checked   = 0;
    int five_table_pixels = 0;
    int three_table_pixels = 0;
    int table_writes      = 0;
    int dropped_writes    = 0;
    int results_seen      = 0;
    int hold_left         = 0;
    int holds_done        = 0;
    int stuck_cycles      = 0;

    lossless_context_and_median_predict #(
        .TABLE_SIZE  (TB_TABLE_SIZE),
        .SAMPLE_BITS (DEF_SAMPLE_BITS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .left         (left),
        .top          (top),
        .top_left     (top_left),
        .top_right    (top_right),
        .left_left    (left_left),
        .top_top      (top_top),
        .table_select (table_select),
        .table_index  (table_index),
        .table_value  (table_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .prediction   (prediction),
        .context_res  (context_res)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // prediction of the block
    // ------------------------------------------------------------------

    // table entry picked by the low bits of a neighbour difference
    function automatic int quant_lookup(int tab, int diff);
        return int'(qtab_model[tab * TB_TABLE_SIZE + (diff & IDX_MASK)]);
    endfunction

    function automatic int median_of3(int a, int b, int c);
        int lo;
        int hi;
        int mid;
        lo  = (a < b) ? a : b;
        hi  = (a < b) ? b : a;
        mid = (hi < c) ? hi : c;
        return (lo > mid) ? lo : mid;
    endfunction

    // table writes update the local tables; compute items queue their result
    function automatic void predict_median_context(pixel_item_t it);
        int l;
        int t;
        int lt;
        int rt;
        int ll;
        int tt;
        int ctx;
        pixel_result_t r;
        if (it.cmd == CMD_WRITE)
        begin
            // writes to a table that does not exist are dropped
            if (int'(it.tsel) < NUM_TABLES && int'(it.tidx) < TB_TABLE_SIZE)
            begin
                qtab_model[int'(it.tsel) * TB_TABLE_SIZE + int'(it.tidx)] = it.tval;
                if (it.tidx == MID_ENTRY && it.tsel == SEL_TABLE3)
                    mid3_set = (it.tval != 0);
                if (it.tidx == MID_ENTRY && it.tsel == SEL_TABLE4)
                    mid4_set = (it.tval != 0);
                table_writes++;
            end
            else
                dropped_writes++;
        end
        else
        begin
            l  = it.left;
            t  = it.top;
            lt = it.top_left;
            rt = it.top_right;
            ll = it.left_left;
            tt = it.top_top;
            // the gradient may leave 16 bits, the median never does
            r.pred = FIELD_W'(median_of3(l, l + t - lt, t));
            ctx = quant_lookup(0, l - lt) + quant_lookup(1, lt - t) + quant_lookup(2, t - rt);
            if (mid3_set || mid4_set)
            begin
                ctx += quant_lookup(3, ll - l) + quant_lookup(4, tt - t);
                five_table_pixels++;
            end
            else
                three_table_pixels++;
            r.ctx = CTX_W'(ctx);
            expected_pixels.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic int random_word();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    // compute item; the table fields carry noise the block must ignore
    function automatic void queue_pixel(int l, int t, int lt, int rt, int ll, int tt);
        pixel_item_t it;
        it.cmd       = CMD_COMPUTE;
        it.left      = FIELD_W'(l);
        it.top       = FIELD_W'(t);
        it.top_left  = FIELD_W'(lt);
        it.top_right = FIELD_W'(rt);
        it.left_left = FIELD_W'(ll);
        it.top_top   = FIELD_W'(tt);
        it.tsel      = SEL_W'($urandom);
        it.tidx      = TIDX_W'($urandom);
        it.tval      = FIELD_W'($urandom);
        pending_items.push_back(it);
    endfunction

    // table write; the sample fields carry noise
    function automatic void queue_write(int sel, int idx, int val);
        pixel_item_t it;
        it.cmd       = CMD_WRITE;
        it.left      = FIELD_W'($urandom);
        it.top       = FIELD_W'($urandom);
        it.top_left  = FIELD_W'($urandom);
        it.top_right = FIELD_W'($urandom);
        it.left_left = FIELD_W'($urandom);
        it.top_top   = FIELD_W'($urandom);
        it.tsel      = SEL_W'(sel);
        it.tidx      = TIDX_W'(idx);
        it.tval      = FIELD_W'(val);
        pending_items.push_back(it);
    endfunction

    // one neighbour sample in the given style around a common base
    function automatic int pick_sample(int style, int base);
        int sign;
        case (style)
            0: return random_word();
            1: return base + int'($urandom_range(0, 32)) - 16;
            2:
            begin
                case ($urandom_range(0, 5))
                    0: return -32768;
                    1: return -1;
                    2: return 0;
                    3: return 32767;
                    4: return 1;
                    default: return -2;
                endcase
            end
            default:
            begin
                // offsets around half a table so the index wraps both ways
                sign = int'($urandom_range(0, 1)) * 2 - 1;
                return base + sign * int'($urandom_range(126, 129));
            end
        endcase
    endfunction

    // close neighbours, as in real images, and full-range noise in equal shares, plus extremes and half-table offsets
    function automatic void queue_random_pixel();
        int r;
        int style;
        int base;
        r     = $urandom_range(0, 9);
        style = (r < 4) ? 0 : (r < 8) ? 1 : (r == 8) ? 2 : 3;
        base  = random_word();
        queue_pixel(pick_sample(style, base), pick_sample(style, base),
                    pick_sample(style, base), pick_sample(style, base),
                    pick_sample(style, base), pick_sample(style, base));
    endfunction

    // random table rewrites that leave entries 0, 127 and the last one alone
    function automatic void queue_rewrites(int n);
        int idx;
        int val;
        repeat (n)
        begin
            idx = $urandom_range(1, TB_TABLE_SIZE - 2);
            if (idx == MID_ENTRY)
                idx++;
            case ($urandom_range(0, 7))
                0: val = -32768;
                1: val = 32767;
                default: val = random_word();
            endcase
            queue_write($urandom_range(0, NUM_TABLES - 1), idx, val);
        end
    endfunction

    // sender pauses until every item is taken and every result is back
    task automatic settle();
        while (pending_items.size() != 0 || in_valid || expected_pixels.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // driver: offers queued items, predicts each one as it is accepted
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_median_context(item_on_bus);
            // load a new item only when the bus is free or just emptied
            if (!in_valid || in_ready)
            begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    item_on_bus   = pending_items.pop_front();
                    in_valid     <= 1'b1;
                    cmd          <= item_on_bus.cmd;
                    left         <= item_on_bus.left;
                    top          <= item_on_bus.top;
                    top_left     <= item_on_bus.top_left;
                    top_right    <= item_on_bus.top_right;
                    left_left    <= item_on_bus.left_left;
                    top_top      <= item_on_bus.top_top;
                    table_select <= item_on_bus.tsel;
                    table_index  <= item_on_bus.tidx;
                    table_value  <= item_on_bus.tval;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stalls, plus two long hold-offs that back up the pipe
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                // one hold-off early in the run, one in the no-idle part
                if (results_seen == 100 || results_seen == 460)
                begin
                    hold_left = HOLD_CYCLES;
                    holds_done++;
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // monitor: each result against the oldest owed one
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("unexpected result: prediction %0d context_res %0d",
                       prediction, context_res);
                errors++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (prediction !== want.pred)
                begin
                    $error("prediction: expected %0d, actual %0d", want.pred, prediction);
                    errors++;
                end
                if (context_res !== want.ctx)
                begin
                    $error("context_res: expected %0d, actual %0d", want.ctx, context_res);
                    errors++;
                end
                results_checked++;
            end
        end
    end

    // watchdog: too long without any handshake means the block is stuck
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stuck_cycles <= 0;
            else if (stuck_cycles == WATCHDOG_LIMIT)
            begin
                $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("Verification failed");
                $finish;
            end
            else
                stuck_cycles <= stuck_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus sequence
    // ------------------------------------------------------------------
    initial
    begin
        int val;
        send_idle_pct = 16;
        recv_idle_pct = 75;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // phase 0: full table load; entry 0 holds the minimum and the last entry
        // the maximum so that the context sum reaches both ends; table 3 mid entry
        // set, table 4 mid entry clear, so five tables are summed
        for (int tab = 0; tab < NUM_TABLES; tab++)
        begin
            for (int idx = 0; idx < TB_TABLE_SIZE; idx++)
            begin
                if (idx == 0)
                    val = -32768;
                else if (idx == IDX_MASK)
                    val = 32767;
                else if (idx == MID_ENTRY && tab == SEL_TABLE3)
                    val = -32768;
                else if (idx == MID_ENTRY && tab == SEL_TABLE4)
                    val = 0;
                else
                    val = random_word();
                queue_write(tab, idx, val);
            end
        end
        // writes aimed past the last table are dropped
        for (int sel = NUM_TABLES; sel < (1 << SEL_W); sel++)
            queue_write(sel, $urandom_range(0, IDX_MASK), random_word());
        settle();

        // directed pixels
        queue_pixel(0, 0, 0, 0, 0, 0);                        // every difference zero
        queue_pixel(-2, 0, -1, 1, -3, -1);                    // every difference minus one
        queue_pixel(32767, 32767, 32767, 32767, 32767, 32767);
        queue_pixel(-32768, -32768, -32768, -32768, -32768, -32768);
        queue_pixel(32767, 32767, -32768, 0, -32768, 32767);  // gradient above range
        queue_pixel(-32768, -32768, 32767, 0, 32767, -32768); // gradient below range
        queue_pixel(32767, -32768, 0, 32767, -32768, 32767);  // widest left-top split
        queue_pixel(5, 10, 12, 3, 7, 9);                      // median is left
        queue_pixel(10, 5, 12, 4, 8, 6);                      // median is top
        queue_pixel(10, 20, 15, 18, 11, 22);                  // median is the gradient
        queue_pixel(0, -1, -128, -128, 127, -129);            // differences near half a table
        queue_pixel(-32768, 32767, 32767, -32768, 32767, -32768); // differences wrap 16 bits
        queue_pixel(127, 128, -128, -127, 255, 256);
        repeat (170) queue_random_pixel();
        settle();

        // phase 1: only table 4 mid entry set; sender idles more than receiver
        send_idle_pct = 75;
        recv_idle_pct = 16;
        queue_write(SEL_TABLE3, MID_ENTRY, 0);
        queue_write(SEL_TABLE4, MID_ENTRY, 32767);
        queue_rewrites(24);
        settle();
        repeat (130) queue_random_pixel();
        settle();

        // phase 2: both mid entries set; no idling from here on
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_write(SEL_TABLE3, MID_ENTRY, 1);
        queue_rewrites(24);
        settle();
        repeat (120) queue_random_pixel();
        settle();

        // phase 3: both mid entries cleared, three tables only
        queue_write(SEL_TABLE3, MID_ENTRY, 0);
        queue_write(SEL_TABLE4, MID_ENTRY, 0);
        queue_rewrites(24);
        settle();
        queue_pixel(0, 0, 0, 0, 0, 0);
        queue_pixel(-2, 0, -1, 1, -3, -1);
        repeat (120) queue_random_pixel();
        settle();

        $display("checked %0d results (%0d with five tables, %0d with three) after %0d table writes",
                 results_checked, five_table_pixels, three_table_pixels, table_writes);
        $display("%0d writes to absent tables dropped, %0d long output hold-offs, three idle mixes",
                 dropped_writes, holds_done);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
